// File: hw/rtl/btnpc_pkg.sv
package btnpc_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int CNT_W       = 8;
    localparam int ID_W        = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 8;

    localparam logic [KIND_W-1:0] KIND_PRESS        = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LONG_PRESS   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE      = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LONG_RELEASE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HOLD    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EVENTS_EN   = 8'd3;

    localparam logic [CNT_W-1:0] RST_SHORT_PRESS = 8'd3;
    localparam logic [CNT_W-1:0] RST_LONG_PRESS  = 8'd50;
    localparam logic [CNT_W-1:0] RST_MAX_HOLD    = 8'd255;

    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [CNT_W-1:0]  t_count;

endpackage

// File: hw/rtl/button_press_classifier.sv
// Button press classifier.
//
// Input channel: one transfer per poll tick, i_pressed_mask holds the level
// of each button (1 = held). Output channel: one transfer per event, with
// o_button_id, o_event_kind and o_last_event, which marks the final event
// of the tick. Ticks that raise no event produce no transfer.
// Configuration channel: i_cfg_valid / o_cfg_ready (always ready), index
// and data; write only while the block is idle. Unknown indexes are dropped.
//
// A tick is classified and the hold counters are updated in the cycle it
// is accepted; its events land in a pending set and move one per cycle into
// the output register while the output is not stalled. The first event
// passes through the pending set and then the output register. The input
// stalls until the pending set has drained; a tick that raises no event
// does not hold off the next one.
// A stalled output holds its event and the pending set waits.
// Reset (synchronous, active low) clears counters, pending events and the
// output valid, and restores the register defaults (3, 50, 255, disabled).
module button_press_classifier
    import btnpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [NUM_BUTTONS-1:0] i_pressed_mask,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [ID_W-1:0]       o_button_id,
    output logic [KIND_W-1:0]     o_event_kind,
    output logic                  o_last_event,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    t_count r_short_ticks;
    t_count r_long_ticks;
    t_count r_max_ticks;
    logic   r_events_en;

    // per-button hold counters
    t_count r_hold_count [NUM_BUTTONS];
    t_count n_hold_count [NUM_BUTTONS];

    // pending events of the current tick
    logic [NUM_BUTTONS-1:0] r_pend_valid;
    logic [NUM_BUTTONS-1:0] n_pend_valid;
    t_kind                  r_pend_kind [NUM_BUTTONS];
    t_kind                  n_pend_kind [NUM_BUTTONS];

    // output register
    logic              r_out_valid;
    logic [ID_W-1:0]   r_out_id;
    t_kind             r_out_kind;
    logic              r_out_last;

    logic                   in_xfer;
    logic                   out_load;
    logic                   sel_found;
    logic [ID_W-1:0]        sel_id;
    logic [NUM_BUTTONS-1:0] rest_valid;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = |r_pend_valid;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_load    = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_button_id  = r_out_id;
    assign o_event_kind = r_out_kind;
    assign o_last_event = r_out_last;

    // classify the incoming tick and advance the counters
    always_comb begin
        logic  held;
        logic  fire;
        t_kind kind;
        t_count c;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            held = i_pressed_mask[i];
            c    = r_hold_count[i];
            fire = 1'b0;
            kind = KIND_PRESS;
            n_hold_count[i] = c;
            if (held) begin
                if (c == r_short_ticks) begin
                    fire = 1'b1;
                    kind = KIND_PRESS;
                end else if (c == r_long_ticks) begin
                    fire = 1'b1;
                    kind = KIND_LONG_PRESS;
                end
                if (c < r_max_ticks) begin
                    n_hold_count[i] = c + t_count'(1);
                end
            end else begin
                if (c >= r_long_ticks) begin
                    fire = 1'b1;
                    kind = KIND_LONG_RELEASE;
                end else if (c >= r_short_ticks) begin
                    fire = 1'b1;
                    kind = KIND_RELEASE;
                end
                n_hold_count[i] = '0;
            end
            n_pend_kind[i]  = kind;
            n_pend_valid[i] = fire && r_events_en;
        end
    end

    // pick the lowest pending button
    always_comb begin
        sel_found  = 1'b0;
        sel_id     = '0;
        rest_valid = r_pend_valid;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (!sel_found && r_pend_valid[i]) begin
                sel_found     = 1'b1;
                sel_id        = ID_W'(i);
                rest_valid[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_ticks <= RST_SHORT_PRESS;
            r_long_ticks  <= RST_LONG_PRESS;
            r_max_ticks   <= RST_MAX_HOLD;
            r_events_en   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_SHORT_PRESS: r_short_ticks <= i_cfg_data;
                REG_LONG_PRESS:  r_long_ticks  <= i_cfg_data;
                REG_MAX_HOLD:    r_max_ticks   <= i_cfg_data;
                REG_EVENTS_EN:   r_events_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // counters and pending set; a tick is only taken when nothing is pending
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_hold_count[i] <= '0;
            end
            r_pend_valid <= '0;
        end else if (in_xfer) begin
            r_hold_count <= n_hold_count;
            r_pend_valid <= n_pend_valid;
        end else if (out_load) begin
            r_pend_valid <= rest_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pend_kind <= n_pend_kind;
        end
    end

    // output register: advance when empty or taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= sel_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && sel_found) begin
            r_out_id   <= sel_id;
            r_out_kind <= r_pend_kind[sel_id];
            r_out_last <= !(|rest_valid);
        end
    end

endmodule
